FILE: hw/rtl/qcuv_pkg.sv
package qcuv_pkg;

  localparam int unsigned PosW    = 20;
  localparam int unsigned TexW    = 16;
  localparam int unsigned ProdW   = PosW + TexW;
  localparam int unsigned NumLane = 4;
  // The quotient never exceeds the texture span, so one stage per quotient bit.
  localparam int unsigned DivSteps = TexW;

  typedef logic signed [PosW-1:0] pos_t;
  typedef logic [TexW-1:0]        tex_t;

  typedef enum logic [1:0] {
    CFG_CLIP_LEFT   = 2'd0,
    CFG_CLIP_TOP    = 2'd1,
    CFG_CLIP_RIGHT  = 2'd2,
    CFG_CLIP_BOTTOM = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    pos_t pos_left;
    pos_t pos_top;
    pos_t pos_right;
    pos_t pos_bottom;
    tex_t tex_u_start;
    tex_t tex_v_start;
    tex_t tex_u_end;
    tex_t tex_v_end;
  } in_t;

  typedef struct packed {
    logic visible;
    pos_t out_left;
    pos_t out_top;
    pos_t out_right;
    pos_t out_bottom;
    tex_t out_u_start;
    tex_t out_v_start;
    tex_t out_u_end;
    tex_t out_v_end;
  } out_t;

  // One lane of the restoring divider: partial remainder, numerator bits
  // still to shift in, quotient so far, and the sign of the texture span.
  typedef struct packed {
    logic [PosW-1:0] rem;
    logic [TexW-1:0] nlo;
    logic [TexW-1:0] quo;
    logic            neg;
  } div_lane_t;

  typedef struct packed {
    logic            vis;
    pos_t            cl;
    pos_t            ct;
    pos_t            cr;
    pos_t            cb;
    tex_t            a_u;
    tex_t            a_v;
    logic [PosW-1:0] w;
    logic [PosW-1:0] h;
    div_lane_t [NumLane-1:0] lane;
  } div_stage_t;

  function automatic div_lane_t div_step(div_lane_t l, logic [PosW-1:0] d);
    logic [PosW:0] t;
    logic          ge;
    div_lane_t     r;
    t     = {l.rem, l.nlo[TexW-1]};
    ge    = (t >= {1'b0, d});
    r     = l;
    r.rem = ge ? PosW'(t - {1'b0, d}) : t[PosW-1:0];
    r.nlo = {l.nlo[TexW-2:0], 1'b0};
    r.quo = {l.quo[TexW-2:0], ge};
    return r;
  endfunction

  // Apply the floor for a negative span and add the start coordinate.
  function automatic tex_t lane_finish(tex_t a, div_lane_t l);
    logic [TexW+1:0] mag;
    logic [TexW+1:0] sq;
    logic [TexW+1:0] sum;
    mag = {2'b00, l.quo} + (TexW+2)'(l.rem != '0);
    sq  = l.neg ? -mag : {2'b00, l.quo};
    sum = {2'b00, a} + sq;
    return sum[TexW-1:0];
  endfunction

endpackage

FILE: hw/rtl/quad_clip_uv_remap_unit.sv
// Channel   Direction  Handshake                  Payload
// cfg       in         cfg_we_i                   cfg_idx_i, cfg_wdata_i
// in        in         in_valid_i / in_ready_o    in_data_i  (qcuv_pkg::in_t)
// out       out        out_valid_o / out_ready_i  out_data_o (qcuv_pkg::out_t)
//
// One item per cycle while the output is not stalled; an accepted item passes
// the clip register, the product register, 16 divider stages (one quotient
// bit each), then the sign fix into the output register.
// The 16-stage restoring divider sets the latency.
// Reset clears the valid bits and sets the scissor to unconstrained extremes.
// A stall freezes every stage at once; in_ready_o is low only while the
// output register holds an item that is not taken.
module quad_clip_uv_remap_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  qcuv_pkg::pos_t   cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  qcuv_pkg::in_t    in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output qcuv_pkg::out_t   out_data_o
);

  localparam int unsigned PosW  = qcuv_pkg::PosW;
  localparam int unsigned TexW  = qcuv_pkg::TexW;
  localparam int unsigned ProdW = qcuv_pkg::ProdW;
  localparam int unsigned NStep = qcuv_pkg::DivSteps;

  qcuv_pkg::pos_t clip_left_q, clip_top_q, clip_right_q, clip_bottom_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_left_q   <= {1'b1, {(PosW-1){1'b0}}};
      clip_top_q    <= {1'b1, {(PosW-1){1'b0}}};
      clip_right_q  <= {1'b0, {(PosW-1){1'b1}}};
      clip_bottom_q <= {1'b0, {(PosW-1){1'b1}}};
    end else if (cfg_we_i) begin
      unique case (qcuv_pkg::cfg_idx_e'(cfg_idx_i))
        qcuv_pkg::CFG_CLIP_LEFT:   clip_left_q   <= cfg_wdata_i;
        qcuv_pkg::CFG_CLIP_TOP:    clip_top_q    <= cfg_wdata_i;
        qcuv_pkg::CFG_CLIP_RIGHT:  clip_right_q  <= cfg_wdata_i;
        qcuv_pkg::CFG_CLIP_BOTTOM: clip_bottom_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic adv;
  logic out_valid_q;
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // ---------------- stage 1: clip ----------------
  logic signed [PosW:0] w_ext, h_ext, off0, off1, off2, off3;
  qcuv_pkg::pos_t cl_d, ct_d, cr_d, cb_d;
  logic signed [TexW:0] du_d, dv_d;
  logic vis_d;

  always_comb begin
    w_ext = {in_data_i.pos_right[PosW-1], in_data_i.pos_right}
          - {in_data_i.pos_left[PosW-1], in_data_i.pos_left};
    h_ext = {in_data_i.pos_bottom[PosW-1], in_data_i.pos_bottom}
          - {in_data_i.pos_top[PosW-1], in_data_i.pos_top};
    cl_d = (in_data_i.pos_left > clip_left_q) ? in_data_i.pos_left : clip_left_q;
    ct_d = (in_data_i.pos_top > clip_top_q) ? in_data_i.pos_top : clip_top_q;
    cr_d = (in_data_i.pos_right < clip_right_q) ? in_data_i.pos_right : clip_right_q;
    cb_d = (in_data_i.pos_bottom < clip_bottom_q) ? in_data_i.pos_bottom : clip_bottom_q;
    vis_d = (w_ext > 0) && (h_ext > 0) && (cr_d > cl_d) && (cb_d > ct_d);
    off0 = {cl_d[PosW-1], cl_d} - {in_data_i.pos_left[PosW-1], in_data_i.pos_left};
    off1 = {ct_d[PosW-1], ct_d} - {in_data_i.pos_top[PosW-1], in_data_i.pos_top};
    off2 = {cr_d[PosW-1], cr_d} - {in_data_i.pos_left[PosW-1], in_data_i.pos_left};
    off3 = {cb_d[PosW-1], cb_d} - {in_data_i.pos_top[PosW-1], in_data_i.pos_top};
    du_d = {1'b0, in_data_i.tex_u_end} - {1'b0, in_data_i.tex_u_start};
    dv_d = {1'b0, in_data_i.tex_v_end} - {1'b0, in_data_i.tex_v_start};
  end

  logic                  s1_vld_q;
  logic                  s1_vis_q;
  qcuv_pkg::pos_t        s1_cl_q, s1_ct_q, s1_cr_q, s1_cb_q;
  qcuv_pkg::tex_t        s1_au_q, s1_av_q;
  logic signed [TexW:0]  s1_du_q, s1_dv_q;
  logic [PosW-1:0]       s1_w_q, s1_h_q;
  logic [PosW-1:0]       s1_off_q [qcuv_pkg::NumLane];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_vis_q    <= vis_d;
      s1_cl_q     <= cl_d;
      s1_ct_q     <= ct_d;
      s1_cr_q     <= cr_d;
      s1_cb_q     <= cb_d;
      s1_au_q     <= in_data_i.tex_u_start;
      s1_av_q     <= in_data_i.tex_v_start;
      s1_du_q     <= du_d;
      s1_dv_q     <= dv_d;
      s1_w_q      <= w_ext[PosW-1:0];
      s1_h_q      <= h_ext[PosW-1:0];
      s1_off_q[0] <= off0[PosW-1:0];
      s1_off_q[1] <= off1[PosW-1:0];
      s1_off_q[2] <= off2[PosW-1:0];
      s1_off_q[3] <= off3[PosW-1:0];
    end
  end

  // ---------------- stage 2: span times offset ----------------
  logic [TexW:0]      absu, absv;
  logic [ProdW-1:0]   prod_d [qcuv_pkg::NumLane];

  always_comb begin
    absu = s1_du_q[TexW] ? 17'(-s1_du_q) : 17'(s1_du_q);
    absv = s1_dv_q[TexW] ? 17'(-s1_dv_q) : 17'(s1_dv_q);
    prod_d[0] = absu[TexW-1:0] * s1_off_q[0];
    prod_d[1] = absv[TexW-1:0] * s1_off_q[1];
    prod_d[2] = absu[TexW-1:0] * s1_off_q[2];
    prod_d[3] = absv[TexW-1:0] * s1_off_q[3];
  end

  logic                 s2_vld_q;
  qcuv_pkg::div_stage_t s2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (adv) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_q.vis <= s1_vis_q;
      s2_q.cl  <= s1_cl_q;
      s2_q.ct  <= s1_ct_q;
      s2_q.cr  <= s1_cr_q;
      s2_q.cb  <= s1_cb_q;
      s2_q.a_u <= s1_au_q;
      s2_q.a_v <= s1_av_q;
      s2_q.w   <= s1_w_q;
      s2_q.h   <= s1_h_q;
      for (int l = 0; l < qcuv_pkg::NumLane; l++) begin
        // The quotient fits in 16 bits, so the top bits already sit below the divisor.
        s2_q.lane[l].rem <= prod_d[l][ProdW-1:TexW];
        s2_q.lane[l].nlo <= prod_d[l][TexW-1:0];
        s2_q.lane[l].quo <= '0;
        s2_q.lane[l].neg <= (l % 2 == 0) ? s1_du_q[TexW] : s1_dv_q[TexW];
      end
    end
  end

  // ---------------- stages 3..18: restoring divider ----------------
  logic [NStep:1]       dv_vld_q;
  qcuv_pkg::div_stage_t dv_q [1:NStep];

  for (genvar k = 1; k <= NStep; k++) begin : g_div
    qcuv_pkg::div_stage_t prev;
    qcuv_pkg::div_stage_t nxt;
    logic                 prev_vld;
    if (k == 1) begin : g_first
      assign prev     = s2_q;
      assign prev_vld = s2_vld_q;
    end else begin : g_next
      assign prev     = dv_q[k-1];
      assign prev_vld = dv_vld_q[k-1];
    end

    always_comb begin
      nxt = prev;
      for (int l = 0; l < qcuv_pkg::NumLane; l++) begin
        nxt.lane[l] = qcuv_pkg::div_step(prev.lane[l], (l % 2 == 0) ? prev.w : prev.h);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[k] <= 1'b0;
      end else if (adv) begin
        dv_vld_q[k] <= prev_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_q[k] <= nxt;
      end
    end
  end

  // ---------------- final stage: floor fix and output register ----------------
  qcuv_pkg::div_stage_t fin;
  qcuv_pkg::out_t       out_d;
  qcuv_pkg::out_t       out_data_q;

  always_comb begin
    fin   = dv_q[NStep];
    out_d = '0;
    if (fin.vis) begin
      out_d.visible     = 1'b1;
      out_d.out_left    = fin.cl;
      out_d.out_top     = fin.ct;
      out_d.out_right   = fin.cr;
      out_d.out_bottom  = fin.cb;
      out_d.out_u_start = qcuv_pkg::lane_finish(fin.a_u, fin.lane[0]);
      out_d.out_v_start = qcuv_pkg::lane_finish(fin.a_v, fin.lane[1]);
      out_d.out_u_end   = qcuv_pkg::lane_finish(fin.a_u, fin.lane[2]);
      out_d.out_v_end   = qcuv_pkg::lane_finish(fin.a_v, fin.lane[3]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dv_vld_q[NStep];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTH
  a_ready_rule : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not follow the output stall");

  a_hidden_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.visible |->
      out_data_o.out_left == '0 && out_data_o.out_right == '0 &&
      out_data_o.out_top == '0 && out_data_o.out_bottom == '0 &&
      out_data_o.out_u_start == '0 && out_data_o.out_u_end == '0 &&
      out_data_o.out_v_start == '0 && out_data_o.out_v_end == '0)
    else $error("hidden quad carries nonzero fields");

  a_visible_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.visible |->
      out_data_o.out_right > out_data_o.out_left &&
      out_data_o.out_bottom > out_data_o.out_top)
    else $error("visible quad is empty");

  a_stall_keeps_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q && !adv |=> s1_vld_q)
    else $error("clip stage lost an item during a stall");
`endif

endmodule
